/* rtl/tsom_pkg.sv */
// Shared types and constants for the three-stack block.
// Holds the command and status codes and the default sizes; no dependencies.
`timescale 1ns / 1ps

package tsom_pkg;

  localparam int REGION_DEPTH_DEF = 32;
  localparam int VALUE_WIDTH_DEF  = 32;
  localparam int NUM_STACKS       = 3;

  localparam int DATA_W   = 32;
  localparam int CMD_W    = 2;
  localparam int SEL_W    = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_TOP   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  localparam logic [SEL_W-1:0] STACK_NONE = 2'd3;

endpackage

/* rtl/tsom_store.sv */
// Element store: single-port synchronous memory with a registered read.
// Uses tsom_pkg only for its default sizes; the top passes the actual sizes.
`timescale 1ns / 1ps

module tsom_store import tsom_pkg::*; #(
  parameter int DEPTH  = 3 * REGION_DEPTH_DEF,
  parameter int WIDTH  = VALUE_WIDTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wr_data,
  output logic [WIDTH-1:0]  rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

endmodule

/* rtl/three_stacks_one_memory.sv */
// Three stacks in one memory: command decode, element counts, result pipeline.
// Depends on tsom_pkg and tsom_store.
// Result: status waits in p1 for the store read, then goes to the output register.
// Throughput: one command per cycle unless stalled by out_ready; single-port store.
// Reset: counts, layout mode and pipeline valids clear; the store is not cleared.
`timescale 1ns / 1ps

module three_stacks_one_memory import tsom_pkg::*; #(
  parameter int REGION_DEPTH = REGION_DEPTH_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [SEL_W-1:0]    in_stack_select,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [STATUS_W-1:0] out_status
);

  localparam int STORE_DEPTH = 3 * REGION_DEPTH;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(2 * REGION_DEPTH + 1);
  localparam int SUM_W       = ADDR_W + 1;
  localparam logic [SUM_W-1:0]   BASE1    = SUM_W'(REGION_DEPTH);
  localparam logic [SUM_W-1:0]   BASE2    = SUM_W'(2 * REGION_DEPTH);
  localparam logic [SUM_W-1:0]   TOP1     = SUM_W'(2 * REGION_DEPTH - 1);
  localparam logic [CNT_W-1:0]   LIM_ONE  = CNT_W'(REGION_DEPTH);
  localparam logic [CNT_W:0]     LIM_PAIR = (CNT_W + 1)'(2 * REGION_DEPTH);

  logic             pending_mode_r;
  logic             active_mode_r;
  logic [CNT_W-1:0] cnt_r [NUM_STACKS];

  logic             p1_valid_r;
  logic             p1_use_rd_r;
  status_t          p1_status_r;

  logic                    out_valid_r;
  logic [DATA_W-1:0]       out_read_value_r;
  status_t                 out_status_r;

  logic accept;
  logic p1_move;
  cmd_t cmd;
  logic sel_ok;
  logic [CNT_W-1:0] cur_cnt;
  logic [CNT_W-1:0] pos;
  logic [CNT_W:0]   pair_sum;
  logic             full;
  status_t          status_nxt;
  logic             use_rd_nxt;
  logic             mem_we;
  logic             mem_re;
  logic [SUM_W-1:0] addr_sum;
  logic [ADDR_W-1:0] mem_addr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [VALUE_WIDTH-1:0] mem_rdata;
  logic [DATA_W-1:0]      rd_word;

  assign cmd      = cmd_t'(in_command);
  assign sel_ok   = (in_stack_select != STACK_NONE);
  assign p1_move  = p1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !p1_valid_r || p1_move;
  assign accept   = in_valid && in_ready;

  // decode, full and empty checks, address of the touched element
  always_comb begin
    cur_cnt    = sel_ok ? cnt_r[in_stack_select] : '0;
    pair_sum   = {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
    if (active_mode_r && in_stack_select != SEL_W'(2)) begin
      full = (pair_sum >= LIM_PAIR);
    end else begin
      full = (cur_cnt >= LIM_ONE);
    end
    pos = (cmd == CMD_PUSH) ? cur_cnt : cur_cnt - CNT_W'(1);
    if (active_mode_r && in_stack_select == SEL_W'(1)) begin
      addr_sum = TOP1 - SUM_W'(pos);
    end else begin
      case (in_stack_select)
        SEL_W'(0): addr_sum = SUM_W'(pos);
        SEL_W'(1): addr_sum = BASE1 + SUM_W'(pos);
        default:   addr_sum = BASE2 + SUM_W'(pos);
      endcase
    end
    mem_addr   = addr_sum[ADDR_W-1:0];
    status_nxt = ST_OK;
    use_rd_nxt = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    case (cmd)
      CMD_CLEAR: status_nxt = ST_OK;
      CMD_PUSH: begin
        if (!sel_ok) begin
          status_nxt = ST_BAD;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          mem_we = accept;
        end
      end
      default: begin
        if (!sel_ok) begin
          status_nxt = ST_BAD;
        end else if (cur_cnt == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          use_rd_nxt = 1'b1;
          mem_re     = accept;
        end
      end
    endcase
  end

  // fit the 32-bit field to the stored width and back
  generate
    if (VALUE_WIDTH > DATA_W) begin : g_wide
      assign mem_wdata = {{(VALUE_WIDTH - DATA_W){1'b0}}, in_push_value};
      assign rd_word   = mem_rdata[DATA_W-1:0];
    end else if (VALUE_WIDTH == DATA_W) begin : g_same
      assign mem_wdata = in_push_value;
      assign rd_word   = mem_rdata;
    end else begin : g_narrow
      assign mem_wdata = in_push_value[VALUE_WIDTH-1:0];
      assign rd_word   = {{(DATA_W - VALUE_WIDTH){1'b0}}, mem_rdata};
    end
  endgenerate

  tsom_store #(
    .DEPTH  (STORE_DEPTH),
    .WIDTH  (VALUE_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk       (clk),
    .wr_en     (mem_we),
    .rd_en     (mem_re),
    .addr      (mem_addr),
    .wr_data   (mem_wdata),
    .rd_data_r (mem_rdata)
  );

  // counts and layout mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_mode_r <= 1'b0;
      active_mode_r  <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        pending_mode_r <= cfg_wr_data;
      end
      if (accept) begin
        if (cmd == CMD_CLEAR) begin
          active_mode_r <= pending_mode_r;
          for (int i = 0; i < NUM_STACKS; i++) begin
            cnt_r[i] <= '0;
          end
        end else if (mem_we) begin
          cnt_r[in_stack_select] <= cur_cnt + CNT_W'(1);
        end else if (mem_re && cmd == CMD_POP) begin
          cnt_r[in_stack_select] <= pos;
        end
      end
    end
  end

  // hold the command's status while the store read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (accept) begin
      p1_valid_r <= 1'b1;
    end else if (p1_move) begin
      p1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_status_r <= status_nxt;
      p1_use_rd_r <= use_rd_nxt;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      out_status_r     <= p1_status_r;
      out_read_value_r <= p1_use_rd_r ? rd_word : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;

endmodule
